@@ hdl/qra_pkg.sv @@
// Shared types and constants of the quadrant ring allocator.
`default_nettype none
package qra_pkg;

  localparam int CounterWidthDefault = 16;
  localparam logic [4:0] MinShift = 5'd6;
  localparam logic [4:0] MaxShift = 5'd24;
  localparam logic [4:0] QuadrantShiftReset = 5'd14;
  localparam logic [11:0] StartOffsetReset = 12'd64;

  localparam logic [1:0] CfgQuadrantShift = 2'd0;
  localparam logic [1:0] CfgStartOffset = 2'd1;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusBusy = 2'd1;
  localparam logic [1:0] StatusTooLarge = 2'd2;
  localparam logic [1:0] StatusOverflow = 2'd3;

  typedef enum logic [2:0] {
    StIdle,
    StPrep,
    StSpan,
    StWrap,
    StQuad,
    StDone
  } qra_state_e;

  typedef struct packed {
    logic load;
    logic prep;
    logic span;
    logic wrap;
    logic quad;
    logic commit;
  } qra_cmd_t;

endpackage
`default_nettype wire

@@ hdl/qra_ctrl.sv @@
// Sequencer that steps one request through the allocator datapath.
`default_nettype none
module qra_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  output qra_pkg::qra_cmd_t    cmd_o
);
  import qra_pkg::*;

  qra_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (start) state_d = StPrep;
      end
      StPrep: state_d = StSpan;
      StSpan: state_d = StWrap;
      StWrap: state_d = StQuad;
      StQuad: state_d = StDone;
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy = 1'b1;
    unique case (state_q)
      StIdle: begin
        busy = 1'b0;
        cmd_o.load = start;
      end
      StPrep: cmd_o.prep = 1'b1;
      StSpan: cmd_o.span = 1'b1;
      StWrap: cmd_o.wrap = 1'b1;
      StQuad: cmd_o.quad = 1'b1;
      StDone: cmd_o.commit = 1'b1;
      default: busy = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/qra_datapath.sv @@
// Address arithmetic, quadrant counters, configuration and result registers.
`default_nettype none
module qra_datapath #(
  parameter int COUNTER_WIDTH = qra_pkg::CounterWidthDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire qra_pkg::qra_cmd_t cmd_i,
  input  wire logic              cfg_valid_i,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [11:0]       cfg_data_i,
  input  wire logic              action_i,
  input  wire logic [24:0]       request_length_i,
  input  wire logic [11:0]       align_mask_i,
  input  wire logic [7:0]        prefix_length_i,
  input  wire logic [25:0]       free_offset_i,
  output logic                   done_o,
  output logic [1:0]             status_o,
  output logic [25:0]            region_offset_o,
  output logic [26:0]            bytes_in_use_o
);
  import qra_pkg::*;

  localparam logic [COUNTER_WIDTH-1:0] CountMax = '1;
  localparam logic [COUNTER_WIDTH-1:0] CountOne = COUNTER_WIDTH'(1);

  logic [4:0]  qshift_q;
  logic [11:0] start_q;
  logic [4:0]  sh;

  logic        action_q;
  logic [24:0] len_q;
  logic [11:0] amask_q;
  logic [7:0]  prefix_q;
  logic [25:0] foff_q;

  logic [26:0] wp_q;
  logic [26:0] alloc_q;
  logic [COUNTER_WIDTH-1:0] cnt_q [4];

  logic [13:0] fit_q;
  logic [27:0] base_q;
  logic [26:0] flast_q;
  logic        big_q;
  logic [28:0] last_q;
  logic [25:0] wlast_q;
  logic [27:0] base_sel_q;
  logic [28:0] last_sel_q;
  logic [1:0]  newq_q;
  logic [1:0]  qa_q, qb_q;
  logic        a_hit_q, b_hit_q, busy_hit_q;
  logic [25:0] region_q;
  logic [26:0] wp_new_q;

  logic        done_q;
  logic [1:0]  status_q;
  logic [25:0] region_out_q;
  logic [26:0] bytes_q;

  always_comb begin
    sh = qshift_q;
    if (qshift_q < MinShift) sh = MinShift;
    if (qshift_q > MaxShift) sh = MaxShift;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qshift_q <= QuadrantShiftReset;
      start_q  <= StartOffsetReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgQuadrantShift) qshift_q <= cfg_data_i[4:0];
      if (cfg_index_i == CfgStartOffset) start_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_i;
      len_q    <= request_length_i;
      amask_q  <= align_mask_i;
      prefix_q <= prefix_length_i;
      foff_q   <= free_offset_i;
    end
  end

  logic [13:0] fit_raw;
  logic [27:0] base_raw;

  assign fit_raw  = 14'(start_q) + 14'(prefix_q) + 14'(amask_q);
  assign base_raw = {1'b0, wp_q} + 28'(prefix_q) + 28'(amask_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      fit_q   <= fit_raw & ~14'(amask_q);
      base_q  <= base_raw & ~28'(amask_q);
      flast_q <= (len_q == '0) ? 27'(foff_q) : 27'(foff_q) + 27'(len_q) - 27'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.span) begin
      big_q   <= (26'(fit_q) + 26'(len_q)) > (26'd1 << sh);
      last_q  <= (len_q == '0) ? 29'(base_q) : 29'(base_q) + 29'(len_q) - 29'd1;
      wlast_q <= (len_q == '0) ? 26'(fit_q) : 26'(fit_q) + 26'(len_q) - 26'd1;
    end
  end

  logic [28:0] newq_full;
  logic        wrap;

  assign newq_full = last_q >> sh;
  assign wrap      = |newq_full[28:2];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wrap) begin
      base_sel_q <= wrap ? 28'(fit_q) : base_q;
      last_sel_q <= wrap ? 29'(wlast_q) : last_q;
      newq_q     <= wrap ? 2'd0 : newq_full[1:0];
    end
  end

  logic [27:0] reg_start;
  logic [1:0]  qa_alloc, qb_alloc;
  logic [26:0] prevq;
  logic        prev_valid;
  logic        new_used;
  logic [25:0] fqa;
  logic [26:0] fqb;

  always_comb begin
    reg_start  = base_sel_q - 28'(prefix_q);
    qa_alloc   = 2'(reg_start >> sh);
    qb_alloc   = 2'(last_sel_q >> sh);
    prev_valid = wp_q != '0;
    prevq      = (wp_q - 27'd1) >> sh;
    new_used   = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (newq_q == 2'(i) && cnt_q[i] != '0) new_used = 1'b1;
    end
    fqa = foff_q >> sh;
    fqb = flast_q >> sh;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.quad) begin
      if (action_q) begin
        qa_q    <= fqa[1:0];
        qb_q    <= fqb[1:0];
        a_hit_q <= fqa < 26'd4;
        b_hit_q <= (fqb != 27'(fqa)) && (fqb < 27'd4);
      end else begin
        qa_q    <= qa_alloc;
        qb_q    <= qb_alloc;
        a_hit_q <= 1'b1;
        b_hit_q <= qa_alloc != qb_alloc;
      end
      busy_hit_q <= (!prev_valid || prevq != 27'(newq_q)) && new_used;
      region_q   <= reg_start[25:0];
      wp_new_q   <= 27'(29'(base_sel_q) + 29'(len_q));
    end
  end

  logic [3:0]  touch;
  logic        ovf;
  logic [1:0]  status_d;
  logic [25:0] total;
  logic [27:0] alloc_sum;
  logic [26:0] alloc_d;

  always_comb begin
    ovf = 1'b0;
    for (int i = 0; i < 4; i++) begin
      touch[i] = (a_hit_q && qa_q == 2'(i)) || (b_hit_q && qb_q == 2'(i));
      if (touch[i] && cnt_q[i] == CountMax) ovf = 1'b1;
    end
    priority if (action_q) status_d = StatusOk;
    else if (big_q) status_d = StatusTooLarge;
    else if (busy_hit_q) status_d = StatusBusy;
    else if (ovf) status_d = StatusOverflow;
    else status_d = StatusOk;
    total     = 26'(len_q) + 26'(prefix_q);
    alloc_sum = 28'(alloc_q) + 28'(total);
    if (action_q) begin
      alloc_d = (alloc_q > 27'(len_q)) ? alloc_q - 27'(len_q) : '0;
    end else if (status_d == StatusOk) begin
      alloc_d = alloc_sum[27] ? '1 : alloc_sum[26:0];
    end else begin
      alloc_d = alloc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= 27'(StartOffsetReset);
      alloc_q <= '0;
      for (int i = 0; i < 4; i++) cnt_q[i] <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.commit;
      if (cmd_i.commit) begin
        alloc_q <= alloc_d;
        if (action_q) begin
          for (int i = 0; i < 4; i++) begin
            if (touch[i] && cnt_q[i] != '0) cnt_q[i] <= cnt_q[i] - CountOne;
          end
        end else if (status_d == StatusOk) begin
          wp_q <= wp_new_q;
          for (int i = 0; i < 4; i++) begin
            if (touch[i]) cnt_q[i] <= cnt_q[i] + CountOne;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q     <= status_d;
      region_out_q <= (!action_q && status_d == StatusOk) ? region_q : '0;
      bytes_q      <= alloc_d;
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign region_offset_o = region_out_q;
  assign bytes_in_use_o  = bytes_q;

endmodule
`default_nettype wire

@@ hdl/quadrant_ring_allocator.sv @@
// Top level of the quadrant ring allocator: sequencer and datapath.
//
// A request is taken when start is high and busy is low. It then passes
// through five datapath steps (alignment, region end, wrap, quadrant lookup,
// commit), and its result word appears on the result ports for one cycle
// with done_o high, in the cycle after the commit; busy is already low in
// that cycle, so a new request can start while the result is shown. No new
// request is taken while an earlier one is still in these steps. The receiver
// cannot stall: a result word must be taken in the cycle that done_o marks.
// Configuration writes are always ready and should be issued only while no
// request is in flight.
`default_nettype none
module quadrant_ring_allocator #(
  parameter int COUNTER_WIDTH = qra_pkg::CounterWidthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        action_i,
  input  wire logic [24:0] request_length_i,
  input  wire logic [11:0] align_mask_i,
  input  wire logic [7:0]  prefix_length_i,
  input  wire logic [25:0] free_offset_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [25:0]      region_offset_o,
  output logic [26:0]      bytes_in_use_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [11:0] cfg_data_i
);
  import qra_pkg::*;

  qra_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  qra_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  qra_datapath #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .action_i         (action_i),
    .request_length_i (request_length_i),
    .align_mask_i     (align_mask_i),
    .prefix_length_i  (prefix_length_i),
    .free_offset_i    (free_offset_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .region_offset_o  (region_offset_o),
    .bytes_in_use_o   (bytes_in_use_o)
  );

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench of the quadrant ring allocator with a built-in predictor.
module tb_top;
  import qra_pkg::*;

  localparam logic ActAlloc = 1'b0;
  localparam logic ActFree = 1'b1;
  localparam logic [1:0] CfgSpare = 2'd3;
  localparam int Quadrants = 4;
  localparam logic [15:0] CounterMax = 16'hFFFF;
  localparam logic [63:0] BytesMax = 64'h7FF_FFFF;
  localparam int unsigned CycleLimit = 2_000_000;
  localparam int SettleCycles = 8;
  localparam int MaxReports = 40;
  localparam int QueueDepth = 4;

  typedef struct packed {
    logic        action;
    logic [24:0] length;
    logic [11:0] mask;
    logic [7:0]  prefix;
    logic [25:0] offset;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [25:0] region;
    logic [26:0] bytes;
  } outcome_t;

  typedef struct packed {
    logic [25:0] offset;
    logic [24:0] length;
  } region_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        action_i = 1'b0;
  logic [24:0] request_length_i = '0;
  logic [11:0] align_mask_i = '0;
  logic [7:0]  prefix_length_i = '0;
  logic [25:0] free_offset_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [25:0] region_offset_o;
  logic [26:0] bytes_in_use_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [11:0] cfg_data_i = '0;

  quadrant_ring_allocator uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .action_i(action_i),
    .request_length_i(request_length_i),
    .align_mask_i(align_mask_i),
    .prefix_length_i(prefix_length_i),
    .free_offset_i(free_offset_i),
    .done_o(done_o),
    .status_o(status_o),
    .region_offset_o(region_offset_o),
    .bytes_in_use_o(bytes_in_use_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  // Predictor copy of the allocator state and registers.
  logic [4:0]  shift_reg = QuadrantShiftReset;
  logic [11:0] start_reg = StartOffsetReset;
  logic [26:0] write_point = 27'(StartOffsetReset);
  logic [15:0] use_count [Quadrants] = '{default: 16'd0};
  logic [26:0] live_bytes = '0;

  request_t    pending_requests [$];
  outcome_t    expected_outcomes [$];
  region_t     live_regions [$];
  request_t    presented;
  int unsigned requests_issued = 0;
  int unsigned results_seen = 0;
  int unsigned overflow_hits = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct = 21;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned clamp_shift(input logic [4:0] s);
    if (s < MinShift) return 32'(MinShift);
    if (s > MaxShift) return 32'(MaxShift);
    return 32'(s);
  endfunction

  function automatic logic [63:0] align_to(input logic [63:0] mask, input logic [63:0] v);
    return (v + mask) & ~mask;
  endfunction

  function automatic logic [63:0] region_end(input logic [63:0] first, input logic [63:0] len);
    return (len != 0) ? first + len - 1 : first;
  endfunction

  task automatic predict_outcome(input request_t r);
    logic [63:0] len, amask, prefix, foff, wp, st, qa, qb, prevq, newq, base, total, sum;
    logic prev_valid;
    int unsigned sh;
    outcome_t o;
    sh = clamp_shift(shift_reg);
    len = 64'(r.length);
    amask = 64'(r.mask);
    prefix = 64'(r.prefix);
    foff = 64'(r.offset);
    wp = 64'(write_point);
    st = 64'(start_reg);
    o.status = StatusOk;
    o.region = '0;
    if (r.action == ActFree) begin
      qa = foff >> sh;
      qb = region_end(foff, len) >> sh;
      if (qa < Quadrants && use_count[qa[1:0]] != 0) use_count[qa[1:0]] -= 16'd1;
      if (qb != qa && qb < Quadrants && use_count[qb[1:0]] != 0) use_count[qb[1:0]] -= 16'd1;
      sum = 64'(live_bytes);
      live_bytes = (sum > len) ? 27'(sum - len) : '0;
    end else if (align_to(amask, st + prefix) + len > (64'd1 << sh)) begin
      o.status = StatusTooLarge;
    end else begin
      prev_valid = (wp != 0);
      prevq = prev_valid ? (wp - 1) >> sh : 64'd0;
      base = align_to(amask, wp + prefix);
      newq = region_end(base, len) >> sh;
      if (newq >= Quadrants) begin
        newq = 0;
        base = align_to(amask, st + prefix);
      end
      qa = ((base - prefix) >> sh) & 64'd3;
      qb = (region_end(base, len) >> sh) & 64'd3;
      total = len + prefix;
      if ((!prev_valid || prevq != newq) && use_count[newq[1:0]] != 0) begin
        o.status = StatusBusy;
      end else if (use_count[qa[1:0]] == CounterMax || use_count[qb[1:0]] == CounterMax) begin
        o.status = StatusOverflow;
        overflow_hits++;
      end else begin
        write_point = 27'(base + len);
        use_count[qa[1:0]] += 16'd1;
        if (qb != qa) use_count[qb[1:0]] += 16'd1;
        sum = live_bytes + total;
        live_bytes = (sum > BytesMax) ? 27'(BytesMax) : sum[26:0];
        o.region = 26'(base - prefix);
        live_regions.push_back('{offset: o.region, length: 25'(total)});
      end
    end
    o.bytes = live_bytes;
    expected_outcomes.push_back(o);
  endtask

  // Driver: a word is taken at an edge where start is high and busy is low.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) predict_outcome(presented);
      if (!start || !busy) begin
        if (pending_requests.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          presented = pending_requests.pop_front();
          start <= 1'b1;
          action_i <= presented.action;
          request_length_i <= presented.length;
          align_mask_i <= presented.mask;
          prefix_length_i <= presented.prefix;
          free_offset_i <= presented.offset;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string what, input longint unsigned e,
                                 input longint unsigned a);
    error_count++;
    if (error_count <= MaxReports)
      $display("%0t %s mismatch: expected %0d actual %0d", $time, what, e, a);
  endtask

  // Monitor: every result word is compared with the oldest expectation.
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (expected_outcomes.size() == 0) begin
        report_mismatch("unexpected result, status", 0, status_o);
      end else begin
        want = expected_outcomes.pop_front();
        if (status_o !== want.status) report_mismatch("status", want.status, status_o);
        if (region_offset_o !== want.region)
          report_mismatch("region_offset", want.region, region_offset_o);
        if (bytes_in_use_o !== want.bytes)
          report_mismatch("bytes_in_use", want.bytes, bytes_in_use_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t timeout with %0d results outstanding", $time, expected_outcomes.size());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_request(input request_t r);
    while (pending_requests.size() >= QueueDepth) @(posedge clk_i);
    pending_requests.push_back(r);
    requests_issued++;
  endtask

  task automatic alloc_item(input logic [24:0] len, input logic [11:0] mask,
                            input logic [7:0] prefix);
    request_t r;
    r.action = ActAlloc;
    r.length = len;
    r.mask = mask;
    r.prefix = prefix;
    r.offset = 26'($urandom);
    push_request(r);
  endtask

  task automatic free_item(input logic [25:0] offset, input logic [24:0] len);
    request_t r;
    r.action = ActFree;
    r.length = len;
    r.mask = 12'($urandom);
    r.prefix = 8'($urandom);
    r.offset = offset;
    push_request(r);
  endtask

  task automatic settle();
    while (results_seen != requests_issued) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [11:0] data);
    repeat ($urandom_range(0, 3)) @(posedge clk_i);
    cfg_index_i <= index;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    if (index == CfgQuadrantShift) shift_reg = data[4:0];
    else if (index == CfgStartOffset) start_reg = data;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic free_live(input int n, input bit newest);
    region_t spot;
    settle();
    repeat (n) begin
      if (live_regions.size() != 0) begin
        spot = newest ? live_regions.pop_back() : live_regions.pop_front();
        free_item(spot.offset, spot.length);
      end
    end
  endtask

  // Zero-length frees at quadrant starts drop every counter to zero.
  task automatic clear_counters();
    int unsigned sh;
    sh = clamp_shift(shift_reg);
    settle();
    while (use_count[0] != 0 || use_count[1] != 0 || use_count[2] != 0 || use_count[3] != 0)
    begin
      for (int q = 0; q < Quadrants; q++)
        if (use_count[q] != 0) free_item(26'(q << sh), 25'd0);
      settle();
    end
  endtask

  task automatic queue_random(input int count, input int unsigned maxlen,
                              input int unsigned prefix_max, input int unsigned mask_bits);
    int unsigned pick, len, idx;
    logic [11:0] mask;
    region_t spot;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, maxlen)
                                          : $urandom_range(1, maxlen / 16 + 1);
        mask = ($urandom_range(0, 9) == 0) ? 12'($urandom)
                                           : 12'((32'd1 << $urandom_range(0, mask_bits)) - 1);
        alloc_item(25'(len), mask, 8'($urandom_range(0, prefix_max)));
      end else if (pick < 90 && live_regions.size() != 0) begin
        idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, live_regions.size() - 1) : 0;
        spot = live_regions[idx];
        live_regions.delete(idx);
        free_item(spot.offset, spot.length);
      end else if (pick < 95) begin
        free_item(26'($urandom), 25'($urandom));
      end else begin
        alloc_item(25'($urandom), 12'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    int unsigned s, qsize, guard;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: 16 KiB quadrants starting at 64.
    alloc_item(25'd1, 12'd0, 8'd0);
    alloc_item(25'd0, 12'hFFF, 8'hFF);
    alloc_item(25'h100_0000, 12'd0, 8'd0);
    alloc_item(25'd16320, 12'd0, 8'd0);
    alloc_item(25'd16320, 12'd0, 8'd1);
    alloc_item(25'd100, 12'h5A5, 8'd7);
    alloc_item(25'd200, 12'hFFF, 8'd0);
    repeat (6) alloc_item(25'd12000, 12'd0, 8'd16);
    free_live(3, 1'b0);
    free_item(26'h3FF_FFFF, 25'h1FF_FFFF);
    free_item(26'd0, 25'd1);
    alloc_item(25'd5000, 12'd63, 8'd4);

    settle();
    write_register(CfgQuadrantShift, {7'($urandom), 5'd8});
    write_register(CfgStartOffset, 12'($urandom_range(0, 63)));
    queue_random(400, 120, 60, 4);

    settle();
    write_register(CfgQuadrantShift, 12'd0);
    write_register(CfgStartOffset, 12'($urandom_range(0, 15)));
    queue_random(250, 30, 12, 3);

    settle();
    write_register(CfgQuadrantShift, 12'd12);
    write_register(CfgStartOffset, 12'hFFF);
    write_register(CfgSpare, 12'($urandom));
    queue_random(60, 2000, 255, 12);

    // Largest quadrants; repeated clearing lets the byte count saturate.
    settle();
    write_register(CfgQuadrantShift, {7'($urandom), 5'd31});
    write_register(CfgStartOffset, 12'd0);
    alloc_item(25'h100_0000, 12'd0, 8'd0);
    repeat (10) begin
      clear_counters();
      alloc_item(25'hFF_F000, 12'd0, 8'd0);
    end
    queue_random(300, 32'h100_0000, 255, 12);

    settle();
    s = $urandom_range(9, 13);
    qsize = 32'd1 << s;
    write_register(CfgQuadrantShift, 12'(s));
    write_register(CfgStartOffset, 12'($urandom_range(0, qsize / 4)));
    queue_random(550, qsize / 3, (qsize / 8 > 255) ? 255 : qsize / 8, 6);

    // Small allocations in one quadrant with no idle cycles.
    settle();
    write_register(CfgQuadrantShift, 12'd24);
    write_register(CfgStartOffset, 12'($urandom));
    idle_pct = 0;
    overflow_hits = 0;
    guard = 0;
    while (overflow_hits < 6 && guard < 40) begin
      alloc_item(25'($urandom_range(1, 32)), 12'((32'd1 << $urandom_range(0, 4)) - 1),
                 8'($urandom_range(0, 31)));
      guard++;
    end
    idle_pct = 21;
    free_live(8, 1'b1);
    repeat (8) alloc_item(25'($urandom_range(1, 32)), 12'd0, 8'($urandom_range(0, 31)));

    settle();
    if (expected_outcomes.size() != 0) begin
      error_count += expected_outcomes.size();
      $display("%0t %0d expected results never arrived", $time, expected_outcomes.size());
    end
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
